// ===== hdl/pgn_tok_pkg.sv =====
package pgn_tok_pkg;

   // Width of the line and column counters
   localparam int POSITION_BITS = 16;
   localparam int ERR_POS_BITS  = 16;

   // Lexer modes
   localparam logic [2:0] MODE_TOP   = 3'd0;
   localparam logic [2:0] MODE_STR   = 3'd1;
   localparam logic [2:0] MODE_ESC   = 3'd2;
   localparam logic [2:0] MODE_LINE  = 3'd3;
   localparam logic [2:0] MODE_BRACE = 3'd4;
   localparam logic [2:0] MODE_SYM   = 3'd5;
   localparam logic [2:0] MODE_DEAD  = 3'd6;

   // Token kinds
   localparam logic [3:0] KIND_STRING   = 4'd0;
   localparam logic [3:0] KIND_LBRACKET = 4'd1;
   localparam logic [3:0] KIND_RBRACKET = 4'd2;
   localparam logic [3:0] KIND_LPAREN   = 4'd3;
   localparam logic [3:0] KIND_RPAREN   = 4'd4;
   localparam logic [3:0] KIND_LANGLE   = 4'd5;
   localparam logic [3:0] KIND_RANGLE   = 4'd6;
   localparam logic [3:0] KIND_STAR     = 4'd7;
   localparam logic [3:0] KIND_PERIOD   = 4'd8;
   localparam logic [3:0] KIND_LINE_CMT = 4'd9;
   localparam logic [3:0] KIND_BRACE_CMT = 4'd10;
   localparam logic [3:0] KIND_EXTENSION = 4'd11;
   localparam logic [3:0] KIND_GLYPH    = 4'd12;
   localparam logic [3:0] KIND_INTEGER  = 4'd13;
   localparam logic [3:0] KIND_SYMBOL   = 4'd14;

   // Error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
   localparam logic [2:0] ERR_BAD_ESCAPE = 3'd2;
   localparam logic [2:0] ERR_OPEN_STR   = 3'd3;
   localparam logic [2:0] ERR_OPEN_BRACE = 3'd4;

   // Characters with a special meaning
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_PERCENT   = 8'h25;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_SEMICOLON = 8'h3B;
   localparam logic [7:0] CH_DOLLAR    = 8'h24;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;

   // One result word
   typedef struct packed {
      logic [3:0]              kind;
      logic [7:0]              value;
      logic                    has;
      logic                    done;
      logic [2:0]              err;
      logic [ERR_POS_BITS-1:0] line;
      logic [ERR_POS_BITS-1:0] column;
      logic                    last;
   } result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_digit(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_sym_char(input logic [7:0] c);
      return is_alnum(c) || (c inside {"_", "+", "#", "=", ":", "-"});
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
   endfunction

endpackage

// ===== hdl/pgn_text_tokenizer_unit.sv =====
// Latency: a byte's first result word is on rsp_ the cycle after the byte is taken.
// Throughput: one byte per cycle while rsp_tready is high and each byte gives at most
// one word; a byte that gives two words (symbol end plus the next token) holds the input
// until its second word is being taken. The two-entry result queue sets that figure.
// Reset: synchronous, active high; clears the queue and returns the lexer to top level
// at line 0, column 0. The same lexer state is restored after each end-of-text byte.
module pgn_text_tokenizer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] value_byte, [8] has_byte, [9] token_done,
                                    // [12:10] error_code, [28:13] error_line,
                                    // [44:29] error_column, [47:45] zero
   output logic [3:0]  rsp_tuser,   // token_kind
   output logic        rsp_tlast    // last_of_run
);
   import pgn_tok_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

   logic [2:0]               mode_ff, mode_in;
   logic                     digits_ff, digits_in;
   logic                     line_start_ff, line_start_in;
   logic [POSITION_BITS-1:0] line_ff, line_in;
   logic [POSITION_BITS-1:0] column_ff, column_in;

   result_type               slot0_ff, slot0_in;
   result_type               slot1_ff, slot1_in;
   logic [1:0]               count_ff, count_in;

   logic                     accept;
   logic                     pop;
   logic [7:0]               c;
   logic                     eot;

   // lexer results for the current byte
   result_type               res0, res1;
   logic [1:0]               res_n;

   // top-level lex outcome
   logic                     top_emit;
   result_type               top_res;
   logic [2:0]               top_mode;
   logic                     top_digits;

   assign c      = req_tdata;
   assign eot    = req_tlast;
   assign pop    = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff == 2'd0) || ((count_ff == 2'd1) && pop);
   assign accept = req_tvalid && req_tready;

   function automatic result_type make_res(
      input logic [3:0]               kind,
      input logic [7:0]               value,
      input logic                     has,
      input logic                     done,
      input logic [2:0]               err,
      input logic [POSITION_BITS-1:0] line,
      input logic [POSITION_BITS-1:0] column
   );
      result_type r;
      r.kind   = kind;
      r.value  = value;
      r.has    = has;
      r.done   = done;
      r.err    = err;
      r.line   = (err != ERR_NONE) ? ERR_POS_BITS'(line) : '0;
      r.column = (err != ERR_NONE) ? ERR_POS_BITS'(column) : '0;
      r.last   = 1'b0;
      return r;
   endfunction

   // Lex one byte at top level
   always_comb begin
      top_emit   = 1'b0;
      top_res    = make_res(KIND_STRING, 8'd0, 1'b0, 1'b0, ERR_NONE, line_ff, column_ff);
      top_mode   = MODE_TOP;
      top_digits = 1'b1;
      case (c)
         "[": begin top_emit = 1'b1;
            top_res = make_res(KIND_LBRACKET, c, 1'b1, 1'b1, ERR_NONE, line_ff, column_ff); end
         "]": begin top_emit = 1'b1;
            top_res = make_res(KIND_RBRACKET, c, 1'b1, 1'b1, ERR_NONE, line_ff, column_ff); end
         "(": begin top_emit = 1'b1;
            top_res = make_res(KIND_LPAREN, c, 1'b1, 1'b1, ERR_NONE, line_ff, column_ff); end
         ")": begin top_emit = 1'b1;
            top_res = make_res(KIND_RPAREN, c, 1'b1, 1'b1, ERR_NONE, line_ff, column_ff); end
         "<": begin top_emit = 1'b1;
            top_res = make_res(KIND_LANGLE, c, 1'b1, 1'b1, ERR_NONE, line_ff, column_ff); end
         ">": begin top_emit = 1'b1;
            top_res = make_res(KIND_RANGLE, c, 1'b1, 1'b1, ERR_NONE, line_ff, column_ff); end
         "*": begin top_emit = 1'b1;
            top_res = make_res(KIND_STAR, c, 1'b1, 1'b1, ERR_NONE, line_ff, column_ff); end
         ".": begin top_emit = 1'b1;
            top_res = make_res(KIND_PERIOD, c, 1'b1, 1'b1, ERR_NONE, line_ff, column_ff); end
         CH_QUOTE: begin
            if (eot) begin
               top_emit = 1'b1;
               top_mode = MODE_DEAD;
               top_res  = make_res(KIND_STRING, 8'd0, 1'b0, 1'b0, ERR_OPEN_STR,
                                   line_ff, column_ff);
            end else begin
               top_mode = MODE_STR;
            end
         end
         CH_SEMICOLON: begin
            if (eot) begin
               top_emit = 1'b1;
               top_res  = make_res(KIND_LINE_CMT, 8'd0, 1'b0, 1'b1, ERR_NONE,
                                   line_ff, column_ff);
            end else begin
               top_mode = MODE_LINE;
            end
         end
         CH_LBRACE: begin
            if (eot) begin
               top_emit = 1'b1;
               top_mode = MODE_DEAD;
               top_res  = make_res(KIND_STRING, 8'd0, 1'b0, 1'b0, ERR_OPEN_BRACE,
                                   line_ff, column_ff);
            end else begin
               top_mode = MODE_BRACE;
            end
         end
         CH_DOLLAR: begin
            top_emit = 1'b1;
            top_res  = make_res(KIND_GLYPH, 8'd0, 1'b0, 1'b1, ERR_NONE, line_ff, column_ff);
         end
         default: begin
            if (is_space(c)) begin
               top_emit = 1'b0;
            end else if ((c == CH_PERCENT) && line_start_ff) begin
               top_emit = 1'b1;
               top_res  = make_res(KIND_EXTENSION, 8'd0, 1'b0, 1'b1, ERR_NONE,
                                   line_ff, column_ff);
            end else if (is_alnum(c)) begin
               top_emit = 1'b1;
               top_res  = make_res(is_digit(c) ? KIND_INTEGER : KIND_SYMBOL, c, 1'b1, eot,
                                   ERR_NONE, line_ff, column_ff);
               if (!eot) begin
                  top_mode   = MODE_SYM;
                  top_digits = is_digit(c);
               end
            end else begin
               top_emit = 1'b1;
               top_mode = MODE_DEAD;
               top_res  = make_res(KIND_STRING, 8'd0, 1'b0, 1'b0, ERR_UNEXPECTED,
                                   line_ff, column_ff);
            end
         end
      endcase
   end

   // Lex one byte in the current mode
   always_comb begin
      res0      = make_res(KIND_STRING, 8'd0, 1'b0, 1'b0, ERR_NONE, line_ff, column_ff);
      res1      = res0;
      res_n     = 2'd0;
      mode_in   = mode_ff;
      digits_in = digits_ff;
      case (mode_ff)
         MODE_STR: begin
            if (eot && (c != CH_QUOTE)) begin
               res_n   = 2'd1;
               mode_in = MODE_DEAD;
               res0    = make_res(KIND_STRING, 8'd0, 1'b0, 1'b0, ERR_OPEN_STR,
                                  line_ff, column_ff);
            end else if (c == CH_BACKSLASH) begin
               mode_in = MODE_ESC;
            end else if (c == CH_QUOTE) begin
               res_n   = 2'd1;
               mode_in = MODE_TOP;
               res0    = make_res(KIND_STRING, 8'd0, 1'b0, 1'b1, ERR_NONE,
                                  line_ff, column_ff);
            end else begin
               res_n = 2'd1;
               res0  = make_res(KIND_STRING, c, 1'b1, 1'b0, ERR_NONE, line_ff, column_ff);
            end
         end
         MODE_ESC: begin
            res_n = 2'd1;
            if ((c != CH_QUOTE) && (c != CH_BACKSLASH)) begin
               mode_in = MODE_DEAD;
               res0    = make_res(KIND_STRING, 8'd0, 1'b0, 1'b0, ERR_BAD_ESCAPE,
                                  line_ff, column_ff);
            end else if (eot) begin
               mode_in = MODE_DEAD;
               res0    = make_res(KIND_STRING, 8'd0, 1'b0, 1'b0, ERR_OPEN_STR,
                                  line_ff, column_ff);
            end else begin
               mode_in = MODE_STR;
               res0    = make_res(KIND_STRING, c, 1'b1, 1'b0, ERR_NONE, line_ff, column_ff);
            end
         end
         MODE_LINE: begin
            res_n = 2'd1;
            if (c == CH_NEWLINE) begin
               mode_in = MODE_TOP;
               res0    = make_res(KIND_LINE_CMT, 8'd0, 1'b0, 1'b1, ERR_NONE,
                                  line_ff, column_ff);
            end else begin
               res0 = make_res(KIND_LINE_CMT, c, 1'b1, eot, ERR_NONE, line_ff, column_ff);
            end
         end
         MODE_BRACE: begin
            res_n = 2'd1;
            if (c == CH_RBRACE) begin
               mode_in = MODE_TOP;
               res0    = make_res(KIND_BRACE_CMT, 8'd0, 1'b0, 1'b1, ERR_NONE,
                                  line_ff, column_ff);
            end else if (eot) begin
               mode_in = MODE_DEAD;
               res0    = make_res(KIND_STRING, 8'd0, 1'b0, 1'b0, ERR_OPEN_BRACE,
                                  line_ff, column_ff);
            end else begin
               res0 = make_res(KIND_BRACE_CMT, c, 1'b1, 1'b0, ERR_NONE, line_ff, column_ff);
            end
         end
         MODE_SYM: begin
            if (is_sym_char(c)) begin
               res_n     = 2'd1;
               digits_in = digits_ff && is_digit(c);
               res0      = make_res(digits_in ? KIND_INTEGER : KIND_SYMBOL, c, 1'b1, eot,
                                    ERR_NONE, line_ff, column_ff);
            end else begin
               // close the symbol, then lex the same byte at top level
               res0      = make_res(digits_ff ? KIND_INTEGER : KIND_SYMBOL, 8'd0, 1'b0,
                                    1'b1, ERR_NONE, line_ff, column_ff);
               res1      = top_res;
               res_n     = top_emit ? 2'd2 : 2'd1;
               mode_in   = top_mode;
               digits_in = top_digits;
            end
         end
         MODE_DEAD: begin
            res_n = 2'd0;
         end
         default: begin
            res0      = top_res;
            res_n     = top_emit ? 2'd1 : 2'd0;
            mode_in   = top_mode;
            digits_in = top_digits;
         end
      endcase

      // mark the final word of this byte
      if (res_n == 2'd2) begin
         res1.last = 1'b1;
      end else begin
         res0.last = 1'b1;
      end

      // advance position
      if (c == CH_NEWLINE) begin
         line_in   = line_ff + POS_ONE;
         column_in = '0;
      end else begin
         line_in   = line_ff;
         column_in = column_ff + POS_ONE;
      end
      line_start_in = (c == CH_NEWLINE);

      // return to reset state after the final byte
      if (eot) begin
         mode_in       = MODE_TOP;
         digits_in     = 1'b1;
         line_start_in = 1'b1;
         line_in       = '0;
         column_in     = '0;
      end
   end

   // Update the result queue
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (accept) begin
         slot0_in = res0;
         slot1_in = res1;
         count_in = res_n;
      end else if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
   end

   // Hold lexer state and queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_TOP;
         digits_ff     <= 1'b1;
         line_start_ff <= 1'b1;
         line_ff       <= '0;
         column_ff     <= '0;
         count_ff      <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            mode_ff       <= mode_in;
            digits_ff     <= digits_in;
            line_start_ff <= line_start_in;
            line_ff       <= line_in;
            column_ff     <= column_in;
         end
      end
   end

   // Hold queue payload
   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // Drive the result word
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tuser  = slot0_ff.kind;
   assign rsp_tlast  = slot0_ff.last;
   assign rsp_tdata  = {3'b000, slot0_ff.column, slot0_ff.line, slot0_ff.err,
                        slot0_ff.done, slot0_ff.has, slot0_ff.value};

endmodule

// ===== sim/pgn_token_checker.sv =====
`timescale 1ns / 1ps

module pgn_token_checker
   import pgn_tok_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // end_of_text
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // [7:0] value, [8] has, [9] done, [12:10] error,
                                    // [28:13] line, [44:29] column, [47:45] zero
   input  logic [3:0]  rsp_tuser,   // token_kind
   input  logic        rsp_tlast,   // last word of the byte
   output int          mismatch_count,
   output int          outstanding,
   output int          words_checked
);

   // Lexer state as the predictor sees it
   logic [2:0]               scan_mode   = MODE_TOP;
   logic                     digits_only = 1'b1;
   logic                     fresh_line  = 1'b1;
   logic [POSITION_BITS-1:0] line_pos    = '0;
   logic [POSITION_BITS-1:0] col_pos     = '0;

   result_type expected_words[$];
   result_type step_words[$];

   initial begin
      mismatch_count = 0;
      words_checked  = 0;
      outstanding    = 0;
   end

   function automatic logic is_numeral(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return is_numeral(c) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_symbol_tail(input logic [7:0] c);
      return is_word_char(c) || c == "_" || c == "+" || c == "#" || c == "=" ||
             c == ":" || c == "-";
   endfunction

   task automatic clear_lexer();
      scan_mode   = MODE_TOP;
      digits_only = 1'b1;
      fresh_line  = 1'b1;
      line_pos    = '0;
      col_pos     = '0;
   endtask

   // Queue one word of the current byte; errors carry the byte's position
   task automatic add_word(input logic [3:0] kind, input logic [7:0] value,
                           input logic has, input logic done, input logic [2:0] err);
      result_type w;
      w.kind   = kind;
      w.value  = value;
      w.has    = has;
      w.done   = done;
      w.err    = err;
      w.line   = (err != ERR_NONE) ? line_pos[ERR_POS_BITS-1:0] : '0;
      w.column = (err != ERR_NONE) ? col_pos[ERR_POS_BITS-1:0] : '0;
      w.last   = 1'b0;
      step_words = {step_words, w};
   endtask

   // Report the error and drop everything until end of text
   task automatic abort_text(input logic [2:0] err);
      scan_mode = MODE_DEAD;
      add_word(KIND_STRING, 8'h00, 1'b0, 1'b0, err);
   endtask

   task automatic lex_at_top(input logic [7:0] c, input logic fin);
      logic [3:0] punct;
      punct = KIND_STRING;
      case (c)
         "[": punct = KIND_LBRACKET;
         "]": punct = KIND_RBRACKET;
         "(": punct = KIND_LPAREN;
         ")": punct = KIND_RPAREN;
         "<": punct = KIND_LANGLE;
         ">": punct = KIND_RANGLE;
         "*": punct = KIND_STAR;
         ".": punct = KIND_PERIOD;
         default: ;
      endcase
      if (punct != KIND_STRING) begin
         add_word(punct, c, 1'b1, 1'b1, ERR_NONE);
      end else if (c == 8'h20 || c == 8'h09 || c == CH_NEWLINE || c == 8'h0B ||
                   c == 8'h0C || c == 8'h0D) begin
         // skip whitespace
      end else if (c == CH_QUOTE) begin
         if (fin) abort_text(ERR_OPEN_STR);
         else scan_mode = MODE_STR;
      end else if (c == CH_SEMICOLON) begin
         if (fin) add_word(KIND_LINE_CMT, 8'h00, 1'b0, 1'b1, ERR_NONE);
         else scan_mode = MODE_LINE;
      end else if (c == CH_LBRACE) begin
         if (fin) abort_text(ERR_OPEN_BRACE);
         else scan_mode = MODE_BRACE;
      end else if (c == CH_PERCENT && fresh_line) begin
         add_word(KIND_EXTENSION, 8'h00, 1'b0, 1'b1, ERR_NONE);
      end else if (c == CH_DOLLAR) begin
         add_word(KIND_GLYPH, 8'h00, 1'b0, 1'b1, ERR_NONE);
      end else if (is_word_char(c)) begin
         if (!fin) begin
            scan_mode   = MODE_SYM;
            digits_only = is_numeral(c);
         end
         add_word(is_numeral(c) ? KIND_INTEGER : KIND_SYMBOL, c, 1'b1, fin, ERR_NONE);
      end else begin
         abort_text(ERR_UNEXPECTED);
      end
   endtask

   // Work out the words one accepted byte must produce
   task automatic predict_byte(input logic [7:0] c, input logic fin);
      step_words.delete();
      case (scan_mode)
         MODE_STR: begin
            if (fin && c != CH_QUOTE) begin
               abort_text(ERR_OPEN_STR);
            end else if (c == CH_BACKSLASH) begin
               scan_mode = MODE_ESC;
            end else if (c == CH_QUOTE) begin
               scan_mode = MODE_TOP;
               add_word(KIND_STRING, 8'h00, 1'b0, 1'b1, ERR_NONE);
            end else begin
               add_word(KIND_STRING, c, 1'b1, 1'b0, ERR_NONE);
            end
         end
         MODE_ESC: begin
            // a bad escape wins over an open string at end of text
            if (c != CH_QUOTE && c != CH_BACKSLASH) begin
               abort_text(ERR_BAD_ESCAPE);
            end else if (fin) begin
               abort_text(ERR_OPEN_STR);
            end else begin
               scan_mode = MODE_STR;
               add_word(KIND_STRING, c, 1'b1, 1'b0, ERR_NONE);
            end
         end
         MODE_LINE: begin
            if (c == CH_NEWLINE) begin
               scan_mode = MODE_TOP;
               add_word(KIND_LINE_CMT, 8'h00, 1'b0, 1'b1, ERR_NONE);
            end else begin
               add_word(KIND_LINE_CMT, c, 1'b1, fin, ERR_NONE);
            end
         end
         MODE_BRACE: begin
            if (c == CH_RBRACE) begin
               scan_mode = MODE_TOP;
               add_word(KIND_BRACE_CMT, 8'h00, 1'b0, 1'b1, ERR_NONE);
            end else if (fin) begin
               abort_text(ERR_OPEN_BRACE);
            end else begin
               add_word(KIND_BRACE_CMT, c, 1'b1, 1'b0, ERR_NONE);
            end
         end
         MODE_SYM: begin
            if (is_symbol_tail(c)) begin
               if (!is_numeral(c)) digits_only = 1'b0;
               add_word(digits_only ? KIND_INTEGER : KIND_SYMBOL, c, 1'b1, fin, ERR_NONE);
            end else begin
               // close the symbol, then lex the same byte from top level
               add_word(digits_only ? KIND_INTEGER : KIND_SYMBOL, 8'h00, 1'b0, 1'b1,
                        ERR_NONE);
               scan_mode   = MODE_TOP;
               digits_only = 1'b1;
               lex_at_top(c, fin);
            end
         end
         MODE_DEAD: ;
         default: lex_at_top(c, fin);
      endcase

      // Advance the position counters
      if (c == CH_NEWLINE) begin
         line_pos = line_pos + POSITION_BITS'(1);
         col_pos  = '0;
      end else begin
         col_pos = col_pos + POSITION_BITS'(1);
      end
      fresh_line = (c == CH_NEWLINE);
      if (fin) clear_lexer();

      // Mark the final word of the byte and hand the words on
      if (step_words.size() > 0) begin
         step_words[step_words.size() - 1].last = 1'b1;
      end
      foreach (step_words[i]) expected_words = {expected_words, step_words[i]};
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Compare result words first: a byte's words never leave in the cycle it is taken
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         expected_words.delete();
         clear_lexer();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word, expected none, got tuser %0h tdata %0h tlast %0b",
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("token_kind", want.kind, rsp_tuser);
               check_field("value_byte", want.value, rsp_tdata[7:0]);
               check_field("has_byte", want.has, rsp_tdata[8]);
               check_field("token_done", want.done, rsp_tdata[9]);
               check_field("error_code", want.err, rsp_tdata[12:10]);
               check_field("error_line", want.line, rsp_tdata[28:13]);
               check_field("error_column", want.column, rsp_tdata[44:29]);
               check_field("tdata padding", 0, rsp_tdata[47:45]);
               check_field("last_of_run", want.last, rsp_tlast);
            end
            words_checked++;
         end
         if (req_tvalid && req_tready) predict_byte(req_tdata, req_tlast);
      end
      outstanding <= expected_words.size();
   end

endmodule

// ===== sim/pgn_text_tokenizer_unit_tb.sv =====
`timescale 1ns / 1ps

module pgn_text_tokenizer_unit_tb;
   import pgn_tok_pkg::*;

   localparam int IDLE_LIMIT   = 3000;
   localparam int RANDOM_BYTES = 700;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_PERIODIC,
      READY_SPARSE
   } ready_style_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tlast  = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [47:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;

   int mismatch_count;
   int outstanding;
   int words_checked;

   int bytes_sent   = 0;
   int texts_sent   = 0;
   int burst_left   = 0;
   int idle_cycles  = 0;
   int random_bytes = 0;
   bit paused       = 1'b0;

   ready_style_type ready_style = READY_ALWAYS;
   logic [5:0]      ready_phase = '0;

   logic [7:0] pgn_text[$];
   logic [7:0] blank_chars [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
   string      punct_chars  = "[]()<>*.";
   string      digit_chars  = "0123456789";
   string      word_chars   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
   string      symbol_chars =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_+#=:-";

   always #5 clock = ~clock;

   pgn_text_tokenizer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   pgn_token_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .words_checked  (words_checked)
   );

   // Stall the result side in windows of varying style, a new style each time ready_phase wraps
   always @(posedge clock) begin
      if (ready_phase == 6'd0) ready_style <= ready_style_type'($urandom_range(0, 3));
      ready_phase <= ready_phase + 6'd1;
      case (ready_style)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_MOSTLY:   rsp_tready <= ($urandom_range(0, 3) != 0);
         READY_PERIODIC: rsp_tready <= (ready_phase[2:0] != 3'd0);
         default:        rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Give up when neither channel moves a word for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Stalled for %0d cycles with %0d words outstanding", IDLE_LIMIT,
                  outstanding);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one byte, with a random gap before each new burst
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // Send the built text, end of text on its final byte
   task automatic send_pgn_text();
      int last_index;
      last_index = pgn_text.size() - 1;
      foreach (pgn_text[i]) send_byte(pgn_text[i], i == last_index);
      pgn_text.delete();
      texts_sent++;
   endtask

   // Append one byte to the text under construction
   task automatic append_byte(input logic [7:0] b);
      pgn_text = {pgn_text, b};
   endtask

   task automatic add_chars(input string s);
      for (int i = 0; i < s.len(); i++) append_byte(s[i]);
   endtask

   // Hold off until every predicted word has come back
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      burst_left = 0;
   endtask

   function automatic logic [7:0] byte_except(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == a || c == b);
      return c;
   endfunction

   // Append one mostly well-formed token, now and then a broken one
   task automatic add_random_token();
      int  pick;
      int  n;
      bit  digits;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         append_byte(blank_chars[$urandom_range(0, 5)]);
      end else if (pick < 30) begin
         append_byte(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
      end else if (pick < 55) begin
         digits = ($urandom_range(0, 2) == 0);
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) begin
            if (digits)
               append_byte(digit_chars[$urandom_range(0, 9)]);
            else if (i == 0)
               append_byte(word_chars[$urandom_range(0, word_chars.len() - 1)]);
            else
               append_byte(symbol_chars[$urandom_range(0, symbol_chars.len() - 1)]);
         end
      end else if (pick < 65) begin
         append_byte(CH_QUOTE);
         repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 4) == 0) begin
               append_byte(CH_BACKSLASH);
               append_byte($urandom_range(0, 1) ? CH_QUOTE : CH_BACKSLASH);
            end else begin
               append_byte(byte_except(CH_QUOTE, CH_BACKSLASH));
            end
         end
         append_byte(CH_QUOTE);
      end else if (pick < 72) begin
         append_byte(CH_SEMICOLON);
         repeat ($urandom_range(0, 6)) append_byte(byte_except(CH_NEWLINE, CH_NEWLINE));
         append_byte(CH_NEWLINE);
      end else if (pick < 79) begin
         append_byte(CH_LBRACE);
         repeat ($urandom_range(0, 6)) append_byte(byte_except(CH_RBRACE, CH_RBRACE));
         append_byte(CH_RBRACE);
      end else if (pick < 83) begin
         append_byte(CH_DOLLAR);
      end else if (pick < 88) begin
         append_byte(CH_NEWLINE);
         append_byte(CH_PERCENT);
      end else begin
         case ($urandom_range(0, 2))
            0: append_byte(8'($urandom_range(0, 255)));
            1: begin
               append_byte(CH_QUOTE);
               append_byte(CH_BACKSLASH);
               append_byte(8'($urandom_range(0, 255)));
            end
            default: begin
               append_byte(8'h20);
               append_byte(CH_PERCENT);
            end
         endcase
      end
   endtask

   // Build a text; cut some short so that they end inside a token
   task automatic build_random_text();
      int target;
      int cut;
      target = $urandom_range(4, 40);
      while (pgn_text.size() < target) add_random_token();
      if ($urandom_range(0, 4) == 0) begin
         cut = $urandom_range(1, pgn_text.size());
         while (pgn_text.size() > cut) void'(pgn_text.pop_back());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Extension at line start, symbol from integer, empty line comment, brace comment,
      // then a percent sign in mid-line
      add_chars("%1a;\n{x} %");
      send_pgn_text();
      // Both escapes, glyph, symbol closed by punctuation, every punctuation mark
      add_chars("\"\\\"\\\\\"$e4.(*)<>[]");
      send_pgn_text();
      // Byte extremes: the zero byte fails, the top byte is dropped after it
      append_byte(8'h00);
      append_byte(8'hFF);
      send_pgn_text();
      // Bad escape at end of text, lone quote, open brace comment
      add_chars("\"\\q");
      send_pgn_text();
      add_chars("\"");
      send_pgn_text();
      add_chars("{c");
      send_pgn_text();
      wait_for_drain();

      while (random_bytes < RANDOM_BYTES) begin
         build_random_text();
         random_bytes += pgn_text.size();
         send_pgn_text();
         if (!paused && random_bytes >= RANDOM_BYTES / 2) begin
            wait_for_drain();
            paused = 1'b1;
         end
      end

      wait_for_drain();
      repeat (8) @(posedge clock);

      $display("Lexed %0d bytes in %0d texts under random gaps and stalls; %0d words checked.",
               bytes_sent, texts_sent, words_checked);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d words never arrived", mismatch_count, outstanding);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/pgn_tok_pkg.sv
hdl/pgn_text_tokenizer_unit.sv
sim/pgn_token_checker.sv
sim/pgn_text_tokenizer_unit_tb.sv
